### hdl/pmve_pkg.sv
// Shared types and constants for the pixel-to-millimetre velocity estimator.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package pmve_pkg;

   // Configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_XX  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_XY  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_YX  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_YY  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_X = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_Y = 3'd5;
   localparam int NUM_CSR = 6;

   // Reset values of the affine transform (Q16.16)
   localparam logic signed [31:0] COEF_ONE  = 32'sd65536;
   localparam logic signed [31:0] COEF_ZERO = 32'sd0;

   // Velocity scaling and divider geometry
   localparam logic [19:0] US_PER_S  = 20'd1000000;
   localparam int NUM_W     = 53;             // 33-bit magnitude times 20-bit scale
   localparam int DIV_STEPS = 31;             // quotient bits below the overflow bound
   localparam int CNT_W     = $clog2(DIV_STEPS);

   localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

   // Controller to datapath commands
   typedef struct packed {
      logic load;       // latch an accepted item
      logic mul_px;     // multiply coefficients by pixel x
      logic mul_py;     // multiply coefficients by pixel y
      logic sum;        // add products and offset, saturate
      logic diff;       // position and time differences
      logic scale;      // magnitude times microseconds per second
      logic div_init;   // overflow check and divider setup
      logic div_step;   // one restoring division step
      logic finish;     // load result register and update track state
   } pmve_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic sample_valid;
      logic zero_dt;
      logic out_free;
   } pmve_sts_type;

endpackage

### hdl/pmve_ctrl.sv
// Sequencer for the velocity estimator: walks one item through multiply,
// sum, difference, scale and divide steps. Depends on pmve_pkg.
`timescale 1ns / 1ps

module pmve_ctrl import pmve_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  pmve_sts_type sts,
   output pmve_cmd_type cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_MULX  = 4'd1;
   localparam logic [3:0] S_MULY  = 4'd2;
   localparam logic [3:0] S_SUM   = 4'd3;
   localparam logic [3:0] S_DIFF  = 4'd4;
   localparam logic [3:0] S_SCALE = 4'd5;
   localparam logic [3:0] S_DINIT = 4'd6;
   localparam logic [3:0] S_DIV   = 4'd7;
   localparam logic [3:0] S_OUT   = 4'd8;

   logic [3:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // Next state and step counter
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         S_IDLE:  if (req_tvalid) state_in = S_MULX;
         S_MULX:  state_in = sts.sample_valid ? S_MULY : S_OUT;
         S_MULY:  state_in = S_SUM;
         S_SUM:   state_in = S_DIFF;
         S_DIFF:  state_in = S_SCALE;
         S_SCALE: state_in = S_DINIT;
         S_DINIT: begin
            cnt_in   = '0;
            state_in = sts.zero_dt ? S_OUT : S_DIV;
         end
         S_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) state_in = S_OUT;
         end
         S_OUT:   if (sts.out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Decode commands from the state
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      cmd          = '0;
      cmd.load     = (state_ff == S_IDLE) && req_tvalid;
      cmd.mul_px   = (state_ff == S_MULX);
      cmd.mul_py   = (state_ff == S_MULY);
      cmd.sum      = (state_ff == S_SUM);
      cmd.diff     = (state_ff == S_DIFF);
      cmd.scale    = (state_ff == S_SCALE);
      cmd.div_init = (state_ff == S_DINIT);
      cmd.div_step = (state_ff == S_DIV);
      cmd.finish   = (state_ff == S_OUT) && sts.out_free;
   end

endmodule

### hdl/pmve_dp.sv
// Datapath of the velocity estimator: configuration registers, affine
// transform, track state, two divider lanes and the result register.
// Depends on pmve_pkg; driven by pmve_ctrl commands.
`timescale 1ns / 1ps

module pmve_dp import pmve_pkg::*; #(
   parameter int PIXEL_BITS = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pmve_cmd_type          cmd,
   output pmve_sts_type          sts,
   input  logic                  in_valid,
   input  logic [PIXEL_BITS-1:0] in_px,
   input  logic [PIXEL_BITS-1:0] in_py,
   input  logic [31:0]           in_stamp,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]           csr_data,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [127:0]          rsp_tdata,
   output logic [1:0]            rsp_tuser
);

   localparam int PW = PIXEL_BITS + 33;   // product width
   localparam int SW = PW + 2;            // sum of two products and offset

   logic signed [31:0] cfg_ff [NUM_CSR];

   logic                  valid_ff;
   logic [PIXEL_BITS-1:0] px_ff, py_ff;
   logic [31:0]           stamp_ff;

   logic signed [31:0] last_ff [2];
   logic [31:0]        last_time_ff;

   logic signed [PW-1:0] prod_px_ff [2];
   logic signed [PW-1:0] prod_py_ff [2];
   logic signed [31:0]   pos_ff [2];
   logic [32:0]          mag_ff [2];
   logic                 neg_ff [2];
   logic [NUM_W-1:0]     num_ff [2];
   logic [32:0]          rem_ff [2];
   logic [DIV_STEPS-1:0] quo_ff [2];
   logic                 ovf_ff [2];
   logic [31:0]          dt_ff;
   logic                 zero_ff;

   logic                 rsp_tvalid_ff;
   logic [127:0]         rsp_tdata_ff;
   logic [1:0]           rsp_tuser_ff;

   logic signed [31:0]   vel [2];
   logic                 out_free;

   // Write configuration registers; indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[CSR_COEF_XX]  <= COEF_ONE;
         cfg_ff[CSR_COEF_XY]  <= COEF_ZERO;
         cfg_ff[CSR_COEF_YX]  <= COEF_ZERO;
         cfg_ff[CSR_COEF_YY]  <= COEF_ONE;
         cfg_ff[CSR_OFFSET_X] <= COEF_ZERO;
         cfg_ff[CSR_OFFSET_Y] <= COEF_ZERO;
      end else if (csr_write && (csr_index < CSR_IDX_W'(NUM_CSR))) begin
         cfg_ff[csr_index] <= csr_data;
      end
   end

   // Latch the accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         px_ff    <= in_px;
         py_ff    <= in_py;
         stamp_ff <= in_stamp;
      end
   end

   // Time difference, wrapping modulo 2^32
   always_ff @(posedge clock) begin
      if (cmd.diff) begin
         dt_ff   <= stamp_ff - last_time_ff;
         zero_ff <= (stamp_ff == last_time_ff);
      end
   end

   // Per-axis lanes: lane 0 is x, lane 1 is y
   for (genvar l = 0; l < 2; l++) begin : g_lane
      logic signed [31:0]           coef_px, coef_py, offset, coef_sel;
      logic signed [PIXEL_BITS:0]   pix_sel;
      logic signed [PW-1:0]         prod;
      logic signed [SW-1:0]         sum;
      logic signed [32:0]           delta;
      logic [NUM_W-1:0]             num;
      logic [32:0]                  rem_sh, rem_sub;
      logic                         take;

      assign coef_px = (l == 0) ? cfg_ff[CSR_COEF_XX]  : cfg_ff[CSR_COEF_YX];
      assign coef_py = (l == 0) ? cfg_ff[CSR_COEF_XY]  : cfg_ff[CSR_COEF_YY];
      assign offset  = (l == 0) ? cfg_ff[CSR_OFFSET_X] : cfg_ff[CSR_OFFSET_Y];

      // One multiplier per lane, used for the x then the y pixel term
      assign coef_sel = cmd.mul_py ? coef_py : coef_px;
      assign pix_sel  = cmd.mul_py ? $signed({1'b0, py_ff}) : $signed({1'b0, px_ff});
      assign prod     = PW'(coef_sel) * PW'(pix_sel);

      always_ff @(posedge clock) begin
         if (cmd.mul_px) prod_px_ff[l] <= prod;
         if (cmd.mul_py) prod_py_ff[l] <= prod;
      end

      // Add both terms and the offset, saturate to 32 bits
      assign sum = SW'(prod_px_ff[l]) + SW'(prod_py_ff[l]) + SW'(offset);

      always_ff @(posedge clock) begin
         if (cmd.sum) begin
            if (sum > SW'(VAL_MAX))      pos_ff[l] <= VAL_MAX;
            else if (sum < SW'(VAL_MIN)) pos_ff[l] <= VAL_MIN;
            else                         pos_ff[l] <= 32'(sum);
         end
      end

      // Sign and magnitude of the position change
      assign delta = 33'(pos_ff[l]) - 33'(last_ff[l]);

      always_ff @(posedge clock) begin
         if (cmd.diff) begin
            neg_ff[l] <= delta[32];
            mag_ff[l] <= delta[32] ? 33'(-delta) : 33'(delta);
         end
      end

      // Scale to per-second units
      assign num = NUM_W'(mag_ff[l]) * NUM_W'(US_PER_S);

      always_ff @(posedge clock) begin
         if (cmd.scale) num_ff[l] <= num;
      end

      // Restoring division: quotient at or above 2^31 saturates, so only
      // the low 31 quotient bits are developed
      assign rem_sh  = {rem_ff[l][31:0], quo_ff[l][DIV_STEPS-1]};
      assign take    = (rem_sh >= {1'b0, dt_ff});
      assign rem_sub = rem_sh - {1'b0, dt_ff};

      always_ff @(posedge clock) begin
         if (cmd.div_init) begin
            ovf_ff[l] <= (32'(num_ff[l][NUM_W-1:DIV_STEPS]) >= dt_ff);
            rem_ff[l] <= 33'(num_ff[l][NUM_W-1:DIV_STEPS]);
            quo_ff[l] <= num_ff[l][DIV_STEPS-1:0];
         end else if (cmd.div_step) begin
            rem_ff[l] <= take ? rem_sub : rem_sh;
            quo_ff[l] <= {quo_ff[l][DIV_STEPS-2:0], take};
         end
      end

      // Final velocity with sign and saturation
      always_comb begin
         if (zero_ff)     vel[l] = '0;
         else if (ovf_ff[l]) vel[l] = neg_ff[l] ? VAL_MIN : VAL_MAX;
         else if (neg_ff[l]) vel[l] = -$signed({1'b0, quo_ff[l]});
         else             vel[l] = $signed({1'b0, quo_ff[l]});
      end

      // Track state moves only on a valid detection
      always_ff @(posedge clock) begin
         if (reset) begin
            last_ff[l] <= '0;
         end else if (cmd.finish && valid_ff) begin
            last_ff[l] <= pos_ff[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff <= '0;
      end else if (cmd.finish && valid_ff) begin
         last_time_ff <= stamp_ff;
      end
   end

   // Result register, parted from the input side
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         if (valid_ff) begin
            rsp_tdata_ff <= {vel[1], vel[0], pos_ff[1], pos_ff[0]};
            rsp_tuser_ff <= {zero_ff, 1'b1};
         end else begin
            rsp_tdata_ff <= '0;
            rsp_tuser_ff <= '0;
         end
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   assign sts.sample_valid = valid_ff;
   assign sts.zero_dt      = zero_ff;
   assign sts.out_free     = out_free;

   // A result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> out_free)
      else $error("result register loaded while occupied");

   // An invalid detection carries an all-zero payload
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !rsp_tuser_ff[0]) |-> (rsp_tdata_ff == '0 && !rsp_tuser_ff[1]))
      else $error("invalid result with nonzero payload");

   // A zero interval forces both velocities to zero
   a_zero_interval: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && rsp_tuser_ff[1]) |-> (rsp_tdata_ff[127:64] == '0))
      else $error("zero interval with nonzero velocity");

   // Divider remainder stays below the divisor unless the lane saturates
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.div_step) |->
         ((ovf_ff[0] || rem_ff[0] < {1'b0, dt_ff}) &&
          (ovf_ff[1] || rem_ff[1] < {1'b0, dt_ff})))
      else $error("divider remainder out of range");

endmodule

### hdl/pixel_to_mm_velocity_estimator.sv
// Top level of the pixel-to-millimetre position and velocity estimator.
// Instantiates pmve_ctrl and pmve_dp; uses pmve_pkg.
`timescale 1ns / 1ps

// Maps each camera detection to table millimetres with a programmable
// affine transform (Q16.16) and reports position plus finite-difference
// velocity against the previous valid detection, in mm/s Q16.16, truncated
// and saturated to 32 bits. One result is returned per item. Items are
// processed one at a time: a valid detection with a nonzero time step
// passes through the 31-step restoring divider (x and y run side by side),
// a zero time step skips the divider and an invalid detection skips all of
// the arithmetic. The result sits in an output register, so the next item
// is accepted while it waits. Program the coefficients only while no item
// is in flight.
module pixel_to_mm_velocity_estimator import pmve_pkg::*; #(
   parameter int PIXEL_BITS = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // pixel_x, pixel_y, stamp_us, zero fill
   input  logic [((2*PIXEL_BITS+32+7)/8)*8-1:0] req_tdata,
   // sample_valid
   input  logic [0:0]           req_tuser,
   // response channel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // position_x, position_y, velocity_x, velocity_y
   output logic [127:0]         rsp_tdata,
   // out_valid, zero_interval
   output logic [1:0]           rsp_tuser,
   // configuration write channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);

   pmve_cmd_type cmd;
   pmve_sts_type sts;

   // Registers always take a write
   assign csr_ready = 1'b1;

   pmve_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   pmve_dp #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .in_valid   (req_tuser[0]),
      .in_px      (req_tdata[PIXEL_BITS-1:0]),
      .in_py      (req_tdata[2*PIXEL_BITS-1:PIXEL_BITS]),
      .in_stamp   (req_tdata[2*PIXEL_BITS+31:2*PIXEL_BITS]),
      .csr_write  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for pixel_to_mm_velocity_estimator: directed corner
// detections, then random tracks under several transform settings.
// Depends on pmve_pkg and the block under test; the expected results are worked out here.

module tb;
   import pmve_pkg::*;

   localparam int PIXEL_BITS    = 12;
   localparam int REQ_W         = ((2*PIXEL_BITS+32+7)/8)*8;
   localparam int STALL_LIMIT   = 4000;
   localparam int DRAIN_CYCLES  = 80;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_ITEMS   = 153;

   // Indexes past the register file; writes there must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef enum int {XFORM_TYPICAL, XFORM_FULL_RANGE, XFORM_EXTREME} xform_kind_type;

   typedef struct packed {
      logic                  sample_valid;
      logic [PIXEL_BITS-1:0] pixel_x;
      logic [PIXEL_BITS-1:0] pixel_y;
      logic [31:0]           stamp_us;
   } detection_type;

   typedef struct packed {
      logic               out_valid;
      logic signed [31:0] position_x;
      logic signed [31:0] position_y;
      logic signed [31:0] velocity_x;
      logic signed [31:0] velocity_y;
      logic               zero_interval;
   } estimate_type;

   // Tracks the transform and the last valid detection, and holds the
   // estimates still owed by the block.
   class track_scoreboard;
      logic signed [31:0] xform [NUM_CSR];
      logic signed [31:0] last_x;
      logic signed [31:0] last_y;
      logic [31:0]        last_stamp;
      estimate_type       owed_q[$];
      int                 errors;
      int                 checked;
      int                 valid_seen;
      int                 zero_seen;

      function new();
         xform[CSR_COEF_XX]  = COEF_ONE;
         xform[CSR_COEF_XY]  = COEF_ZERO;
         xform[CSR_COEF_YX]  = COEF_ZERO;
         xform[CSR_COEF_YY]  = COEF_ONE;
         xform[CSR_OFFSET_X] = COEF_ZERO;
         xform[CSR_OFFSET_Y] = COEF_ZERO;
         last_x     = '0;
         last_y     = '0;
         last_stamp = '0;
         errors     = 0;
         checked    = 0;
         valid_seen = 0;
         zero_seen  = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
         if (idx < NUM_CSR) xform[idx] = value;
      endfunction

      function logic signed [31:0] clamp32(longint v);
         if (v > longint'(VAL_MAX)) return VAL_MAX;
         if (v < longint'(VAL_MIN)) return VAL_MIN;
         return v[31:0];
      endfunction

      // Position change times 1e6 over the interval, truncated, saturated
      function logic signed [31:0] mm_per_s(logic signed [31:0] now_pos,
                                            logic signed [31:0] was_pos,
                                            logic [31:0] dt);
         longint          diff;
         longint unsigned mag;
         longint unsigned quo;
         diff = longint'(now_pos) - longint'(was_pos);
         mag  = (diff < 0) ? -diff : diff;
         quo  = (mag * {44'd0, US_PER_S}) / {32'd0, dt};
         if (diff < 0) return (quo >= 64'h8000_0000) ? VAL_MIN : -$signed(quo[31:0]);
         return (quo > 64'h7FFF_FFFF) ? VAL_MAX : $signed(quo[31:0]);
      endfunction

      function void note_detection(detection_type d);
         estimate_type e;
         longint       acc_x;
         longint       acc_y;
         logic [31:0]  dt;
         e = '0;
         if (d.sample_valid) begin
            acc_x = longint'(xform[CSR_COEF_XX]) * longint'(d.pixel_x)
                  + longint'(xform[CSR_COEF_XY]) * longint'(d.pixel_y)
                  + longint'(xform[CSR_OFFSET_X]);
            acc_y = longint'(xform[CSR_COEF_YX]) * longint'(d.pixel_x)
                  + longint'(xform[CSR_COEF_YY]) * longint'(d.pixel_y)
                  + longint'(xform[CSR_OFFSET_Y]);
            e.out_valid  = 1'b1;
            e.position_x = clamp32(acc_x);
            e.position_y = clamp32(acc_y);
            dt = d.stamp_us - last_stamp;
            e.zero_interval = (dt == 32'd0);
            if (!e.zero_interval) begin
               e.velocity_x = mm_per_s(e.position_x, last_x, dt);
               e.velocity_y = mm_per_s(e.position_y, last_y, dt);
            end
            // advance the track
            last_x     = e.position_x;
            last_y     = e.position_y;
            last_stamp = d.stamp_us;
            valid_seen++;
            if (e.zero_interval) zero_seen++;
         end
         owed_q.push_back(e);
      endfunction

      task report_mismatch(string what);
         errors++;
         $display("mismatch at result %0d: %s", checked, what);
      endtask

      task check_result(logic [127:0] data, logic [1:0] user);
         estimate_type e;
         checked++;
         if (owed_q.size() == 0) begin
            report_mismatch("result arrived with no detection pending");
            return;
         end
         e = owed_q.pop_front();
         if (user[0] !== e.out_valid)
            report_mismatch($sformatf("out_valid %0b, want %0b", user[0], e.out_valid));
         if (user[1] !== e.zero_interval)
            report_mismatch($sformatf("zero_interval %0b, want %0b", user[1], e.zero_interval));
         if ($signed(data[31:0]) !== e.position_x)
            report_mismatch($sformatf("position_x %0d, want %0d",
                                      $signed(data[31:0]), e.position_x));
         if ($signed(data[63:32]) !== e.position_y)
            report_mismatch($sformatf("position_y %0d, want %0d",
                                      $signed(data[63:32]), e.position_y));
         if ($signed(data[95:64]) !== e.velocity_x)
            report_mismatch($sformatf("velocity_x %0d, want %0d",
                                      $signed(data[95:64]), e.velocity_x));
         if ($signed(data[127:96]) !== e.velocity_y)
            report_mismatch($sformatf("velocity_y %0d, want %0d",
                                      $signed(data[127:96]), e.velocity_y));
      endtask
   endclass

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata  = '0;    // pixel_x, pixel_y, stamp_us
   logic [0:0]           req_tuser  = '0;    // sample_valid
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [127:0]         rsp_tdata;          // position_x, position_y, velocity_x, velocity_y
   logic [1:0]           rsp_tuser;          // out_valid, zero_interval
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [31:0]          csr_data   = '0;

   track_scoreboard sb;
   int              send_idle_pct = 0;
   int              recv_idle_pct = 0;
   int              hold_left     = 0;
   int              quiet_cycles  = 0;
   int              settings_done = 0;
   logic [PIXEL_BITS-1:0] px_now    = '0;
   logic [PIXEL_BITS-1:0] py_now    = '0;
   logic [31:0]           stamp_now = '0;

   pixel_to_mm_velocity_estimator #(.PIXEL_BITS(PIXEL_BITS)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Check each accepted result, then pick the next ready with random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
         if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(0, 99) < recv_idle_pct) begin
            hold_left  <= $urandom_range(0, 6);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run when no channel has moved an item for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", quiet_cycles);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic detection_type make_item(logic v, logic [PIXEL_BITS-1:0] x,
                                               logic [PIXEL_BITS-1:0] y, logic [31:0] s);
      detection_type d;
      d.sample_valid = v;
      d.pixel_x      = x;
      d.pixel_y      = y;
      d.stamp_us     = s;
      return d;
   endfunction

   function automatic logic [PIXEL_BITS-1:0] nudge(logic [PIXEL_BITS-1:0] p);
      int v;
      v = int'(p) + int'($urandom_range(0, 80)) - 40;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return v[PIXEL_BITS-1:0];
   endfunction

   // Mostly a plausible track: small moves at frame-like intervals, with
   // repeated stamps, jumps, tiny intervals and dropped detections mixed in
   function automatic detection_type next_detection();
      detection_type d;
      int            pick;
      pick = $urandom_range(0, 99);
      d = make_item(1'b1, PIXEL_BITS'($urandom), PIXEL_BITS'($urandom), $urandom);
      if (pick < 8) begin
         d.sample_valid = 1'b0;
      end else begin
         if ($urandom_range(0, 1)) begin
            d.pixel_x = nudge(px_now);
            d.pixel_y = nudge(py_now);
         end
         if (pick < 15)       d.stamp_us = stamp_now;
         else if (pick < 23)  d.stamp_us = $urandom;
         else if (pick < 33)  d.stamp_us = stamp_now + $urandom_range(1, 20);
         else                 d.stamp_us = stamp_now + $urandom_range(1000, 100000);
      end
      return d;
   endfunction

   task automatic send_detection(detection_type d);
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'({d.stamp_us, d.pixel_y, d.pixel_x});
      req_tuser  <= d.sample_valid;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_detection(d);
      if (d.sample_valid) begin
         px_now    = d.pixel_x;
         py_now    = d.pixel_y;
         stamp_now = d.stamp_us;
      end
   endtask

   // Hold the sender until every owed result has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.owed_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_register(idx, value);
   endtask

   task automatic program_transform(xform_kind_type kind);
      logic [31:0] value;
      logic [31:0] mag;
      for (int i = 0; i < NUM_CSR; i++) begin
         case (kind)
            XFORM_TYPICAL: begin
               mag   = (i >= CSR_OFFSET_X) ? $urandom_range(0, 1 << 26)
                                           : $urandom_range(0, 3 * 65536);
               value = $urandom_range(0, 1) ? -mag : mag;
            end
            XFORM_FULL_RANGE: begin
               value = $urandom;
            end
            default: begin
               case ($urandom_range(0, 5))
                  0: value = VAL_MAX;
                  1: value = VAL_MIN;
                  2: value = COEF_ZERO;
                  3: value = 32'hFFFF_FFFF;
                  4: value = 32'd1;
                  default: value = COEF_ONE;
               endcase
            end
         endcase
         write_register(CSR_IDX_W'(i), value);
      end
      if ($urandom_range(0, 1))
         write_register($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI, $urandom);
      csr_valid <= 1'b0;
      settings_done++;
   endtask

   initial begin
      xform_kind_type kind;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset transform, first detection, saturated rates, wrap
      send_detection(make_item(1'b0, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF));
      send_detection(make_item(1'b1, 12'h000, 12'h000, 32'h0000_0000));
      send_detection(make_item(1'b1, 12'hFFF, 12'hFFF, 32'h0000_0001));
      send_detection(make_item(1'b1, 12'h000, 12'h000, 32'h0000_0002));
      send_detection(make_item(1'b1, 12'hFFF, 12'h000, 32'h0000_0002));
      send_detection(make_item(1'b0, 12'h000, 12'h000, 32'h0000_0000));
      send_detection(make_item(1'b1, 12'd100, 12'd200, 32'hFFFF_FFF0));
      send_detection(make_item(1'b1, 12'd101, 12'd199, 32'h0000_0010));
      send_detection(make_item(1'b1, 12'h800, 12'h400, 32'h8000_0010));
      send_detection(make_item(1'b1, 12'h7FF, 12'hBFF, 32'h800F_4250));
      send_detection(make_item(1'b1, 12'h555, 12'hAAA, 32'h800F_836B));
      wait_drained();
      settings_done++;

      // Extreme transform: positions pinned at both rails, spare indexes
      write_register(CSR_COEF_XX, VAL_MAX);
      write_register(CSR_COEF_XY, VAL_MAX);
      write_register(CSR_COEF_YX, VAL_MIN);
      write_register(CSR_COEF_YY, VAL_MIN);
      write_register(CSR_OFFSET_X, VAL_MAX);
      write_register(CSR_OFFSET_Y, VAL_MIN);
      write_register(CSR_SPARE_LO, 32'h0000_0000);
      write_register(CSR_SPARE_HI, 32'hFFFF_FFFF);
      csr_valid <= 1'b0;
      settings_done++;
      send_detection(make_item(1'b1, 12'hFFF, 12'hFFF, 32'h800F_836C));
      send_detection(make_item(1'b1, 12'h000, 12'h000, 32'h800F_836D));
      send_detection(make_item(1'b1, 12'h001, 12'h000, 32'h800F_836E));
      send_detection(make_item(1'b0, 12'hFFF, 12'h000, 32'h800F_836F));
      send_detection(make_item(1'b1, 12'h000, 12'h001, 32'h800F_836E));
      wait_drained();

      // Zero weights, offsets swapped: full-scale jump over one microsecond
      write_register(CSR_COEF_XX, COEF_ZERO);
      write_register(CSR_COEF_XY, COEF_ZERO);
      write_register(CSR_COEF_YX, COEF_ZERO);
      write_register(CSR_COEF_YY, COEF_ZERO);
      write_register(CSR_OFFSET_X, VAL_MIN);
      write_register(CSR_OFFSET_Y, VAL_MAX);
      csr_valid <= 1'b0;
      settings_done++;
      send_detection(make_item(1'b1, 12'hFFF, 12'h001, 32'h800F_836F));
      send_detection(make_item(1'b1, 12'h123, 12'h456, 32'h800F_836E));

      // Random tracks, one transform per phase; phase 2 and the last phase without idling
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_drained();
         kind = (phase % 4 == 1) ? XFORM_FULL_RANGE :
                (phase % 4 == 3) ? XFORM_EXTREME : XFORM_TYPICAL;
         program_transform(kind);
         if (phase == 2 || phase == RANDOM_PHASES - 1) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end else begin
            send_idle_pct = $urandom_range(10, 40);
            recv_idle_pct = $urandom_range(10, 40);
         end
         repeat (PHASE_ITEMS) send_detection(next_detection());
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.owed_q.size() != 0) sb.report_mismatch("detections left without a result");

      $display("Checked %0d results: %0d valid detections, %0d zero intervals, %0d settings.",
               sb.checked, sb.valid_seen, sb.zero_seen, settings_done);
      $display("Random stalls on both channels, %0d mismatches.", sb.errors);
      if (sb.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
